### hw/rtl/rfcs_pkg.sv
package rfcs_pkg;

    // command codes
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_IO    = 2'd2;
    localparam logic [1:0] CMD_EXIT  = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_POLICY  = 2'd0;
    localparam logic [1:0] CFG_QUANTUM = 2'd1;
    localparam logic [1:0] CFG_ACTIVE  = 2'd2;

    localparam logic [7:0]  DEFAULT_QUANTUM = 8'd3;
    localparam logic [4:0]  DEFAULT_ACTIVE  = 5'd10;
    localparam logic [30:0] TICK_MAX        = 31'h7FFF_FFFF;
    localparam logic [31:0] NEVER           = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        ST_READY = 2'd0,
        ST_RUN   = 2'd1,
        ST_SLEEP = 2'd2,
        ST_DONE  = 2'd3
    } t_status;

    typedef struct packed {
        t_status     status;
        logic [7:0]  quantum;
        logic [3:0]  sleep_left;
        logic [30:0] enqueue_time;
        logic [31:0] wait_total;
        logic [31:0] sleep_total;
        logic [15:0] io_requests;
        logic [31:0] first_dispatch;
    } t_slot_rec;

    typedef struct packed {
        logic [1:0] command;
        logic [3:0] slot;
        logic [3:0] io_ticks;
    } t_req;

    typedef struct packed {
        logic               running_valid;
        logic [3:0]         running_index;
        logic               ticked_valid;
        logic [3:0]         ticked_index;
        logic               dispatched;
        logic [31:0]        switch_count;
        logic [30:0]        tick_count;
        logic               all_done;
        logic [31:0]        exit_wait;
        logic [31:0]        exit_io_time;
        logic [15:0]        exit_io_count;
        logic signed [31:0] exit_first_run;
    } t_res;

    function automatic t_slot_rec reset_rec();
        t_slot_rec r;
        r                = '0;
        r.status         = ST_DONE;
        r.first_dispatch = NEVER;
        return r;
    endfunction

    function automatic logic [31:0] sat32(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    function automatic logic [15:0] sat16(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

endpackage

### hw/rtl/rfcs_slot_mem.sv
// slot table, one record per slot, registered read
module rfcs_slot_mem #(
    parameter int SLOTS = 16,
    parameter int IW    = 4
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [IW-1:0]        i_waddr,
    input  rfcs_pkg::t_slot_rec  i_wdata,
    input  logic [IW-1:0]        i_raddr,
    output rfcs_pkg::t_slot_rec  o_rdata
);

    rfcs_pkg::t_slot_rec mem [SLOTS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

### hw/rtl/rr_fcfs_process_scheduler_core.sv
// Event-driven process scheduler over a table of SLOTS process slots, round
// robin with a per-slot quantum or first come first served. Pulse i_start
// with a request while o_busy is low; exactly one result comes back on o_res,
// marked by a one-cycle o_res_valid strobe, and the receiver cannot stall it:
// sample it in that cycle. The slot table sits in a single memory with a
// registered read; tick, refill, dispatch, io and exit accesses each read a
// slot before any write to it, while a start sweep only writes. A start
// resets every slot; a tick walks the table from the cursor, in round robin
// walks it again to refill quanta when none is left, then may dispatch a
// slot. An exit beyond the table goes straight to the result. Configuration
// writes are always taken (o_cfg_ready high) and must only be made while
// the block is idle. Results are returned in request order.
module rr_fcfs_process_scheduler_core #(
    parameter int SLOTS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    output logic            o_busy,
    input  rfcs_pkg::t_req  i_req,
    output logic            o_res_valid,
    output rfcs_pkg::t_res  o_res,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [1:0]      i_cfg_index,
    input  logic [7:0]      i_cfg_data
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int LW = $clog2(SLOTS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_FILL, S_T_RD, S_T_WR, S_R_RD, S_R_WR, S_PICK,
        S_D_RD, S_D_WR, S_X_RD, S_X_WR, S_EMIT
    } t_state;

    t_state              r_state;
    logic [IW-1:0]       r_k;
    logic [1:0]          r_cmd;
    logic [3:0]          r_iot;
    logic                r_policy;
    logic [7:0]          r_quantum;
    logic [4:0]          r_active;
    logic [IW-1:0]       r_cur;
    logic                r_cpu_busy;
    logic [IW-1:0]       r_cursor;
    logic [30:0]         r_tick;
    logic [31:0]         r_switch;
    logic [LW-1:0]       r_live;
    logic                r_loaded;
    logic                r_ticked;
    logic [IW-1:0]       r_ticked_idx;
    logic                r_disp;
    logic                r_any;
    logic                r_refill;
    logic                r_ca_v;      // first ready slot from the cursor
    logic [IW-1:0]       r_ca_idx;
    logic                r_cb_v;      // first ready slot with quantum left
    logic [IW-1:0]       r_cb_idx;
    logic                r_best_v;    // oldest ready slot
    logic [IW-1:0]       r_best_idx;
    logic [30:0]         r_best_enq;
    logic [IW-1:0]       r_pick;
    logic [IW-1:0]       r_xaddr;
    logic [31:0]         r_ex_wait;
    logic [31:0]         r_ex_io_time;
    logic [15:0]         r_ex_io_count;
    logic [31:0]         r_ex_first;
    logic                r_res_valid;
    rfcs_pkg::t_res      r_res;

    rfcs_pkg::t_slot_rec mem_rdata;
    rfcs_pkg::t_slot_rec rd;
    rfcs_pkg::t_slot_rec tick_rec;
    rfcs_pkg::t_slot_rec wdata;
    logic                we;
    logic [IW-1:0]       acc_addr;
    logic [IW-1:0]       scan_addr;
    logic [IW:0]         scan_sum;
    logic [7:0]          eff_q;
    logic                rr;
    logic                tk;
    logic                preempt;
    logic                n_any;
    logic                last_k;
    logic                fcfs_better;
    logic [IW-1:0]       slot_addr;
    logic [IW+3:0]       slot_w;
    logic [IW+3:0]       cur_w;
    logic [IW+3:0]       tkd_w;
    logic                accept;

    assign accept      = i_start && (r_state == S_IDLE);
    assign o_busy      = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    assign rr     = !r_policy;
    assign eff_q  = (r_quantum == 8'd0) ? rfcs_pkg::DEFAULT_QUANTUM : r_quantum;
    assign last_k = (int'(r_k) == SLOTS - 1);

    // rotation order for the tick pass: cursor + k modulo SLOTS
    assign scan_sum  = {1'b0, r_cursor} + {1'b0, r_k};
    assign scan_addr = (scan_sum >= (IW+1)'(SLOTS)) ?
                       IW'(scan_sum - (IW+1)'(SLOTS)) : scan_sum[IW-1:0];

    assign slot_w    = {{IW{1'b0}}, i_req.slot};
    assign slot_addr = slot_w[IW-1:0];
    assign cur_w     = {4'b0, r_cur};
    assign tkd_w     = {4'b0, r_ticked_idx};

    // table reads as reset contents until the first start has swept it
    assign rd = r_loaded ? mem_rdata : rfcs_pkg::reset_rec();

    always_comb begin
        unique case (r_state)
            S_T_RD, S_T_WR: acc_addr = scan_addr;
            S_D_RD, S_D_WR: acc_addr = r_pick;
            S_X_RD, S_X_WR: acc_addr = r_xaddr;
            default:        acc_addr = r_k;
        endcase
    end

    // per-slot tick update: waits, sleeps, charge of the running slot
    always_comb begin
        tick_rec = rd;
        tk       = 1'b0;
        preempt  = 1'b0;
        unique case (rd.status)
            rfcs_pkg::ST_READY: begin
                tick_rec.wait_total = rfcs_pkg::sat32(rd.wait_total);
            end
            rfcs_pkg::ST_SLEEP: begin
                tick_rec.sleep_total = rfcs_pkg::sat32(rd.sleep_total);
                if (rd.sleep_left <= 4'd1) begin
                    tick_rec.sleep_left   = 4'd0;
                    tick_rec.status       = rfcs_pkg::ST_READY;
                    tick_rec.enqueue_time = r_tick;
                end else begin
                    tick_rec.sleep_left = rd.sleep_left - 4'd1;
                end
            end
            rfcs_pkg::ST_RUN: begin
                if (r_cpu_busy && acc_addr == r_cur) begin
                    tk = 1'b1;
                    if (rr) begin
                        if (rd.quantum != 8'd0) begin
                            tick_rec.quantum = rd.quantum - 8'd1;
                        end
                        if (rd.quantum <= 8'd1) begin
                            tick_rec.status       = rfcs_pkg::ST_READY;
                            tick_rec.enqueue_time = r_tick;
                            preempt               = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
        n_any = r_any || (tick_rec.status != rfcs_pkg::ST_DONE &&
                          tick_rec.quantum != 8'd0);
        fcfs_better = !r_best_v || (tick_rec.enqueue_time < r_best_enq) ||
                      (tick_rec.enqueue_time == r_best_enq && acc_addr < r_best_idx);
    end

    // write port
    always_comb begin
        we    = 1'b0;
        wdata = rd;
        unique case (r_state)
            S_FILL: begin
                we    = 1'b1;
                wdata = rfcs_pkg::reset_rec();
                if (int'(r_k) < int'(r_active)) begin
                    wdata.status  = rfcs_pkg::ST_READY;
                    wdata.quantum = r_policy ? 8'd1 : eff_q;
                end
            end
            S_T_WR: begin
                we    = 1'b1;
                wdata = tick_rec;
            end
            S_R_WR: begin
                we = 1'b1;
                if (rd.status != rfcs_pkg::ST_DONE) begin
                    wdata.quantum = eff_q;
                end
            end
            S_D_WR: begin
                we           = 1'b1;
                wdata.status = rfcs_pkg::ST_RUN;
                if (rd.first_dispatch == rfcs_pkg::NEVER) begin
                    wdata.first_dispatch = {1'b0, r_tick};
                end
            end
            S_X_WR: begin
                if (r_cmd == rfcs_pkg::CMD_IO) begin
                    if (r_cpu_busy && rd.status == rfcs_pkg::ST_RUN) begin
                        we                = 1'b1;
                        wdata.status      = rfcs_pkg::ST_SLEEP;
                        wdata.sleep_left  = r_iot;
                        wdata.io_requests = rfcs_pkg::sat16(rd.io_requests);
                    end
                end else if (rd.status != rfcs_pkg::ST_DONE) begin
                    we           = 1'b1;
                    wdata.status = rfcs_pkg::ST_DONE;
                end
            end
            default: ;
        endcase
    end

    rfcs_slot_mem #(
        .SLOTS (SLOTS),
        .IW    (IW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (acc_addr),
        .i_wdata (wdata),
        .i_raddr (acc_addr),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_k         <= '0;
            r_cmd       <= rfcs_pkg::CMD_START;
            r_iot       <= '0;
            r_policy    <= 1'b0;
            r_quantum   <= rfcs_pkg::DEFAULT_QUANTUM;
            r_active    <= rfcs_pkg::DEFAULT_ACTIVE;
            r_cur       <= '0;
            r_cpu_busy  <= 1'b0;
            r_cursor    <= '0;
            r_tick      <= '0;
            r_switch    <= '0;
            r_live      <= '0;
            r_loaded    <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            // strobe for exactly the cycle after the emit state
            r_res_valid <= (r_state == S_EMIT);
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    rfcs_pkg::CFG_POLICY:  r_policy  <= i_cfg_data[0];
                    rfcs_pkg::CFG_QUANTUM: r_quantum <= i_cfg_data;
                    rfcs_pkg::CFG_ACTIVE:  r_active  <= i_cfg_data[4:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_cmd         <= i_req.command;
                        r_iot         <= i_req.io_ticks;
                        r_k           <= '0;
                        r_ticked      <= 1'b0;
                        r_ticked_idx  <= '0;
                        r_disp        <= 1'b0;
                        r_ex_wait     <= '0;
                        r_ex_io_time  <= '0;
                        r_ex_io_count <= '0;
                        r_ex_first    <= '0;
                        unique case (i_req.command)
                            rfcs_pkg::CMD_START: begin
                                r_cur      <= '0;
                                r_cpu_busy <= 1'b0;
                                r_tick     <= '0;
                                r_switch   <= '0;
                                r_live     <= (int'(r_active) > SLOTS) ?
                                              LW'(SLOTS) : LW'(r_active);
                                r_state    <= S_FILL;
                            end
                            rfcs_pkg::CMD_TICK: begin
                                if (r_tick != rfcs_pkg::TICK_MAX) begin
                                    r_tick <= r_tick + 31'd1;
                                end
                                r_any    <= 1'b0;
                                r_refill <= 1'b0;
                                r_ca_v   <= 1'b0;
                                r_cb_v   <= 1'b0;
                                r_best_v <= 1'b0;
                                r_state  <= S_T_RD;
                            end
                            rfcs_pkg::CMD_IO: begin
                                r_xaddr <= r_cur;
                                r_state <= S_X_RD;
                            end
                            default: begin
                                r_xaddr <= slot_addr;
                                r_state <= (int'(i_req.slot) < SLOTS) ? S_X_RD : S_EMIT;
                            end
                        endcase
                    end
                end
                S_FILL: begin
                    r_k <= r_k + IW'(1);
                    if (last_k) begin
                        r_loaded <= 1'b1;
                        r_state  <= S_EMIT;
                    end
                end
                S_T_RD: r_state <= S_T_WR;
                S_T_WR: begin
                    if (tk) begin
                        r_ticked     <= 1'b1;
                        r_ticked_idx <= acc_addr;
                    end
                    if (preempt) begin
                        r_cpu_busy <= 1'b0;
                    end
                    r_any <= n_any;
                    if (tick_rec.status == rfcs_pkg::ST_READY) begin
                        if (!r_ca_v) begin
                            r_ca_v   <= 1'b1;
                            r_ca_idx <= acc_addr;
                        end
                        if (!r_cb_v && tick_rec.quantum != 8'd0) begin
                            r_cb_v   <= 1'b1;
                            r_cb_idx <= acc_addr;
                        end
                        if (fcfs_better) begin
                            r_best_v   <= 1'b1;
                            r_best_idx <= acc_addr;
                            r_best_enq <= tick_rec.enqueue_time;
                        end
                    end
                    if (last_k) begin
                        r_k <= '0;
                        if (rr && !n_any) begin
                            r_refill <= 1'b1;
                            r_state  <= S_R_RD;
                        end else begin
                            r_state <= S_PICK;
                        end
                    end else begin
                        r_k     <= r_k + IW'(1);
                        r_state <= S_T_RD;
                    end
                end
                S_R_RD: r_state <= S_R_WR;
                S_R_WR: begin
                    r_k     <= r_k + IW'(1);
                    r_state <= last_k ? S_PICK : S_R_RD;
                end
                S_PICK: begin
                    // oldest ready slot in fcfs, first from the cursor in rr
                    if (!r_cpu_busy && !rr && r_best_v) begin
                        r_pick  <= r_best_idx;
                        r_state <= S_D_RD;
                    end else if (!r_cpu_busy && rr && r_refill && r_ca_v) begin
                        r_pick  <= r_ca_idx;
                        r_state <= S_D_RD;
                    end else if (!r_cpu_busy && rr && !r_refill && r_cb_v) begin
                        r_pick  <= r_cb_idx;
                        r_state <= S_D_RD;
                    end else begin
                        r_state <= S_EMIT;
                    end
                end
                S_D_RD: r_state <= S_D_WR;
                S_D_WR: begin
                    r_switch   <= rfcs_pkg::sat32(r_switch);
                    r_cur      <= r_pick;
                    r_cpu_busy <= 1'b1;
                    r_disp     <= 1'b1;
                    if (rr) begin
                        r_cursor <= (int'(r_pick) == SLOTS - 1) ? '0 : r_pick + IW'(1);
                    end
                    r_state <= S_EMIT;
                end
                S_X_RD: r_state <= S_X_WR;
                S_X_WR: begin
                    if (r_cmd == rfcs_pkg::CMD_IO) begin
                        if (r_cpu_busy && rd.status == rfcs_pkg::ST_RUN) begin
                            r_cpu_busy <= 1'b0;
                        end
                    end else begin
                        if (rd.status != rfcs_pkg::ST_DONE) begin
                            r_live <= r_live - LW'(1);
                            if (r_cpu_busy && r_cur == r_xaddr) begin
                                r_cpu_busy <= 1'b0;
                            end
                        end
                        r_ex_wait     <= rd.wait_total;
                        r_ex_io_time  <= rd.sleep_total;
                        r_ex_io_count <= rd.io_requests;
                        r_ex_first    <= rd.first_dispatch;
                    end
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    r_res.running_valid  <= r_cpu_busy;
                    r_res.running_index  <= r_cpu_busy ? cur_w[3:0] : 4'd0;
                    r_res.ticked_valid   <= r_ticked;
                    r_res.ticked_index   <= r_ticked ? tkd_w[3:0] : 4'd0;
                    r_res.dispatched     <= r_disp;
                    r_res.switch_count   <= r_switch;
                    r_res.tick_count     <= r_tick;
                    r_res.all_done       <= (r_live == '0);
                    r_res.exit_wait      <= r_ex_wait;
                    r_res.exit_io_time   <= r_ex_io_time;
                    r_res.exit_io_count  <= r_ex_io_count;
                    r_res.exit_first_run <= r_ex_first;
                    r_state              <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // result strobe only while idle, never two in a row
    a_res_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> !o_busy)
        else $error("result strobe while busy");

    a_res_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> !o_res_valid)
        else $error("result strobe longer than one cycle");

    a_run_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.running_valid) |-> !o_res.all_done)
        else $error("running slot reported with all slots done");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("request accepted without going busy");

endmodule
